>>> design/text_console_writer_top_defines.svh
// Assertion macros for the text console writer.
// Used by text_console_writer_top; expects signals clk and rst in scope.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Used by the controller, the datapath and the top level; no dependencies.
package tcw_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SCROLL = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  // Configuration register indexes
  localparam logic CFG_BG = 1'b0;
  localparam logic CFG_FG = 1'b1;

  localparam logic [3:0] BG_RESET = 4'd0;
  localparam logic [3:0] FG_RESET = 4'd7;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] TAB_CHAR     = 8'h09;

  // Blank cell in the reset colors
  localparam logic [15:0] RESET_CELL = {BG_RESET, FG_RESET, SPACE_CHAR};

  // Source of the word written to the screen memory
  typedef enum logic [1:0] {
    WR_CURSOR,
    WR_COPY,
    WR_BLANK,
    WR_INIT
  } wr_src_t;

  // Source of the screen memory read address
  typedef enum logic {
    RD_INPUT,
    RD_COPY
  } rd_src_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    wr_en;
    wr_src_t wr_src;
    logic    rd_en;
    rd_src_t rd_src;
    logic    idx_clear;
    logic    idx_inc;
    logic    advance;
    logic    home;
    logic    cursor_up;
    logic    out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    put_more;
    logic    wrap_last;
    logic    idx_copy_last;
    logic    idx_last;
    logic    out_free;
  } status_t;

endpackage

>>> design/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port and one read port; no dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath through cmd_t and reads status_t.
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        op_in,
  input  tcw_pkg::status_t  status,
  output tcw_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_COPY_RD,
    S_COPY_WR,
    S_BLANK,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    logic finish;
    finish     = 1'b0;
    state_next = state;
    cmd        = '0;
    cmd.wr_src = tcw_pkg::WR_CURSOR;
    cmd.rd_src = tcw_pkg::RD_INPUT;

    unique case (state)
      S_INIT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = tcw_pkg::WR_INIT;
        cmd.idx_inc = 1'b1;
        if (status.idx_last) begin
          cmd.idx_clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch = 1'b1;
          unique case (tcw_pkg::opcode_t'(op_in))
            tcw_pkg::OP_PUT: begin
              state_next = S_PUT;
            end
            tcw_pkg::OP_CLEAR: begin
              cmd.idx_clear = 1'b1;
              state_next    = S_CLEAR;
            end
            tcw_pkg::OP_SCROLL: begin
              cmd.idx_clear = 1'b1;
              state_next    = S_COPY_RD;
            end
            tcw_pkg::OP_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = tcw_pkg::RD_INPUT;
              state_next = S_DONE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = tcw_pkg::WR_CURSOR;
        cmd.advance = 1'b1;
        priority if (status.wrap_last) begin
          cmd.idx_clear = 1'b1;
          state_next    = S_COPY_RD;
        end else if (status.put_more) begin
          state_next = S_PUT;
        end else begin
          finish = 1'b1;
        end
      end
      S_COPY_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = tcw_pkg::RD_COPY;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = tcw_pkg::WR_COPY;
        cmd.idx_inc = 1'b1;
        state_next  = status.idx_copy_last ? S_BLANK : S_COPY_RD;
      end
      S_BLANK: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = tcw_pkg::WR_BLANK;
        cmd.idx_inc = 1'b1;
        if (status.idx_last) begin
          // Only an explicit scroll moves the cursor; a wrap already placed it
          cmd.cursor_up = (status.op == tcw_pkg::OP_SCROLL);
          finish        = 1'b1;
        end
      end
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = tcw_pkg::WR_BLANK;
        cmd.idx_inc = 1'b1;
        cmd.home    = 1'b1;
        finish      = status.idx_last;
      end
      S_DONE: begin
        finish = 1'b1;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase

    // Hand the result over, or hold it until the output register frees
    if (finish) begin
      if (status.out_free) begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end else begin
        state_next = S_DONE;
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/tcw_datapath.sv
// Datapath of the text console writer: cursor, colors, cell counter,
// screen memory and output register. Depends on tcw_pkg and tcw_ram.
module tcw_datapath #(
  parameter int ROWS     = 25,
  parameter int COLUMNS  = 80,
  parameter int TAB_STOP = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_en,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic [1:0]        op_in,
  input  logic [7:0]        char_in,
  input  logic [10:0]       addr_in,
  input  tcw_pkg::cmd_t     cmd,
  output tcw_pkg::status_t  status,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [15:0]       read_data,
  output logic [4:0]        cursor_row,
  output logic [6:0]        cursor_column
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW  = $clog2(CELL_COUNT);
  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLUMNS);
  localparam int TPW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  logic [RW-1:0]    row, row_next;
  logic [CW-1:0]    col, col_next;
  logic [TPW-1:0]   phase, phase_next;
  logic [AW-1:0]    idx;
  logic [3:0]       bg, fg;
  tcw_pkg::opcode_t op_q;
  logic [7:0]       char_q;
  logic             addr_ok_q;

  logic             in_addr_ok;
  logic [AW-1:0]    cursor_addr;
  logic [7:0]       put_char;
  logic             ram_wen, ram_ren;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [15:0]      ram_wdata, ram_rdata;

  assign in_addr_ok  = (32'(addr_in) < 32'(CELL_COUNT));
  assign cursor_addr = AW'(row * COLUMNS) + AW'(col);
  assign put_char    = (char_q == tcw_pkg::NEWLINE_CHAR || char_q == tcw_pkg::TAB_CHAR) ?
                       tcw_pkg::SPACE_CHAR : char_q;

  // Cursor update; phase tracks the column modulo the tab stop
  always_comb begin
    row_next   = row;
    col_next   = col;
    phase_next = phase;
    priority if (cmd.home) begin
      row_next   = '0;
      col_next   = '0;
      phase_next = '0;
    end else if (cmd.advance) begin
      if (col == CW'(COLUMNS - 1)) begin
        col_next   = '0;
        phase_next = '0;
        if (row != RW'(ROWS - 1)) begin
          row_next = row + RW'(1);
        end
      end else begin
        col_next   = col + CW'(1);
        phase_next = (phase == TPW'(TAB_STOP - 1)) ? '0 : phase + TPW'(1);
      end
    end else if (cmd.cursor_up) begin
      if (row != '0) begin
        row_next = row - RW'(1);
      end else begin
        col_next   = '0;
        phase_next = '0;
      end
    end
  end

  // Status toward the controller
  always_comb begin
    status.op            = op_q;
    status.wrap_last     = (col == CW'(COLUMNS - 1)) && (row == RW'(ROWS - 1));
    status.put_more      = (char_q == tcw_pkg::NEWLINE_CHAR && col_next != '0) ||
                           (char_q == tcw_pkg::TAB_CHAR && phase_next != '0);
    status.idx_copy_last = (idx == AW'(CELL_COUNT - COLUMNS - 1));
    status.idx_last      = (idx == AW'(CELL_COUNT - 1));
    status.out_free      = !m_tvalid || m_tready;
  end

  // Screen memory port selection
  always_comb begin
    ram_wen   = cmd.wr_en;
    ram_waddr = (cmd.wr_src == tcw_pkg::WR_CURSOR) ? cursor_addr : idx;
    unique case (cmd.wr_src)
      tcw_pkg::WR_CURSOR: ram_wdata = {bg, fg, put_char};
      tcw_pkg::WR_COPY:   ram_wdata = ram_rdata;
      tcw_pkg::WR_BLANK:  ram_wdata = {bg, fg, tcw_pkg::SPACE_CHAR};
      tcw_pkg::WR_INIT:   ram_wdata = tcw_pkg::RESET_CELL;
      default:            ram_wdata = tcw_pkg::RESET_CELL;
    endcase
    if (cmd.rd_src == tcw_pkg::RD_INPUT) begin
      ram_raddr = AW'(addr_in);
      ram_ren   = cmd.rd_en && in_addr_ok;
    end else begin
      ram_raddr = idx + AW'(COLUMNS);
      ram_ren   = cmd.rd_en;
    end
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .wen  (ram_wen),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .ren  (ram_ren),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control registers: cursor, cell counter, colors, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      phase    <= '0;
      idx      <= '0;
      bg       <= tcw_pkg::BG_RESET;
      fg       <= tcw_pkg::FG_RESET;
      m_tvalid <= 1'b0;
    end else begin
      row   <= row_next;
      col   <= col_next;
      phase <= phase_next;
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + AW'(1);
      end
      if (cfg_en) begin
        unique case (cfg_index)
          tcw_pkg::CFG_BG: bg <= cfg_data;
          tcw_pkg::CFG_FG: fg <= cfg_data;
          default:         bg <= bg;
        endcase
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers: latched transaction and result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q      <= tcw_pkg::opcode_t'(op_in);
      char_q    <= char_in;
      addr_ok_q <= in_addr_ok;
    end
    if (cmd.out_load) begin
      read_data     <= (op_q == tcw_pkg::OP_READ && addr_ok_q) ? ram_rdata : 16'd0;
      cursor_row    <= 5'(row_next);
      cursor_column <= 7'(col_next);
    end
  end

endmodule

>>> design/text_console_writer_top.sv
// Top level of the text console writer: stream ports, config port, assertions.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath, tcw_ram and the defines header.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  s_      | s_tvalid/s_tready  | tuser opcode; tdata char_code, cell_address
//  m_      | m_tvalid/m_tready  | tdata read_data, cursor_row, cursor_column
//  cfg_    | cfg_en             | cfg_index, cfg_data (bg_color, fg_color)
//
// A newline or tab puts spaces up to the next row or tab stop; a put that wraps
// past the last row also scrolls the screen.
// The single-port-per-side screen memory writes one cell per cycle, and a copy
// costs a read and a write.
// After reset a clearing pass over every cell runs with s_tready low.
// A result waits in the output register; the next transaction is taken meanwhile,
// and only its own result holds until m_tready frees that register.

`include "text_console_writer_top_defines.svh"

module text_console_writer_top #(
  parameter int ROWS     = 25,
  parameter int COLUMNS  = 80,
  parameter int TAB_STOP = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_address, [23:19] zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] read_data, [20:16] cursor_row,
                                 // [27:21] cursor_column, [31:28] zero
  input  logic        cfg_en,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;
  logic [15:0]      read_data;
  logic [4:0]       cursor_row;
  logic [6:0]       cursor_column;

  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .op_in   (s_tuser),
    .status  (status),
    .cmd     (cmd)
  );

  tcw_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .TAB_STOP(TAB_STOP)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_en       (cfg_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op_in        (s_tuser),
    .char_in      (s_tdata[7:0]),
    .addr_in      (s_tdata[18:8]),
    .cmd          (cmd),
    .status       (status),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .read_data    (read_data),
    .cursor_row   (cursor_row),
    .cursor_column(cursor_column)
  );

  // Pack the result
  assign m_tdata = {4'd0, cursor_column, cursor_row, read_data};

  // Screen writes happen only while no transaction can be taken
  `TCW_ASSERT_IMPLIES(a_no_write_when_ready, cmd.wr_en, !s_tready, "write while ready")
  // Never overwrite a result that is still waiting
  `TCW_ASSERT_IMPLIES(a_load_when_free, cmd.out_load, status.out_free, "result overwritten")
  // A loaded result is offered in the next cycle
  `TCW_ASSERT_NEXT(a_load_shows_valid, cmd.out_load, m_tvalid, "loaded result not offered")
  // Offered cursor lies on the screen
  `TCW_ASSERT_IMPLIES(a_cursor_in_range, m_tvalid,
                      (32'(m_tdata[20:16]) < 32'(ROWS)) && (32'(m_tdata[27:21]) < 32'(COLUMNS)),
                      "cursor off screen")

endmodule

>>> verif/tb_text_console_writer_top.sv
// Testbench for text_console_writer_top: screen mirror, cursor predictor and stream checker.
// Depends on tcw_pkg and the text_console_writer_top RTL; reads no files.
module tb_text_console_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS        = 25;
  localparam int COLUMNS     = 80;
  localparam int TAB_STOP    = 4;
  localparam int CELL_COUNT  = ROWS * COLUMNS;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    logic [15:0] read_word;
    logic [4:0]  row;
    logic [6:0]  column;
  } console_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [3:0]  cfg_data = '0;

  // Screen mirror, cursor and colors as the block should hold them
  logic [15:0] screen_mirror [CELL_COUNT];
  int unsigned cursor_y;
  int unsigned cursor_x;
  logic [3:0]  bg_now;
  logic [3:0]  fg_now;

  console_reply_t replies_due [$];
  int fail_count  = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;
  int hold_request = 0;
  int stall_left   = 0;

  text_console_writer_top #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .TAB_STOP(TAB_STOP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_en   (cfg_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] colored(logic [7:0] ch);
    return {bg_now, fg_now, ch};
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_mirror[i] = colored(tcw_pkg::SPACE_CHAR);
    cursor_y = 0;
    cursor_x = 0;
  endfunction

  // Move rows up, blank the last one, pull the cursor up or home its column on row 0
  function automatic void shift_rows();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_mirror[i] = screen_mirror[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
      screen_mirror[i] = colored(tcw_pkg::SPACE_CHAR);
    end
    if (cursor_y != 0) cursor_y--;
    else cursor_x = 0;
  endfunction

  // Write at the cursor, then advance with column wrap and bottom scroll
  function automatic void place_char(logic [7:0] ch);
    screen_mirror[cursor_y * COLUMNS + cursor_x] = colored(ch);
    cursor_x++;
    if (cursor_x >= COLUMNS) begin
      cursor_x = 0;
      cursor_y++;
      if (cursor_y >= ROWS) begin
        shift_rows();
        cursor_y = ROWS - 1;
      end
    end
  endfunction

  function automatic void type_char(logic [7:0] ch);
    if (ch == tcw_pkg::NEWLINE_CHAR) begin
      do place_char(tcw_pkg::SPACE_CHAR); while (cursor_x != 0);
    end else if (ch == tcw_pkg::TAB_CHAR) begin
      do place_char(tcw_pkg::SPACE_CHAR); while ((cursor_x % TAB_STOP) != 0);
    end else begin
      place_char(ch);
    end
  endfunction

  function automatic console_reply_t console_apply(tcw_pkg::opcode_t op, logic [7:0] ch,
                                                   logic [10:0] addr);
    console_reply_t r;
    r.read_word = '0;
    case (op)
      tcw_pkg::OP_PUT:    type_char(ch);
      tcw_pkg::OP_CLEAR:  blank_screen();
      tcw_pkg::OP_SCROLL: shift_rows();
      tcw_pkg::OP_READ: begin
        if (addr < CELL_COUNT) r.read_word = screen_mirror[addr];
      end
    endcase
    r.row    = cursor_y[4:0];
    r.column = cursor_x[6:0];
    return r;
  endfunction

  // Offer one command, with random idle gaps unless steady; predict once the transaction is taken
  task automatic send_command(tcw_pkg::opcode_t op, logic [7:0] ch, logic [10:0] addr);
    while (!steady && $urandom_range(0, 99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'd0, addr, ch};
    do @(posedge clk); while (!s_tready);
    replies_due.push_back(console_apply(op, ch, addr));
  endtask

  // Hold the input until every expected result has come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_colors(logic [3:0] bg, logic [3:0] fg);
    wait_idle();
    cfg_en    <= 1'b1;
    cfg_index <= tcw_pkg::CFG_BG;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_index <= tcw_pkg::CFG_FG;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_en <= 1'b0;
    @(posedge clk);
    bg_now = bg;
    fg_now = fg;
  endtask

  // Receiver: random stalls, or a long hold-off counted here when requested
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_request != 0 || stall_left != 0) begin
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 34);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_replies
    console_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        $error("result with nothing expected: m_tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = replies_due.pop_front();
        if (m_tdata[15:0] !== want.read_word) begin
          $error("read_data: expected %h, got %h", want.read_word, m_tdata[15:0]);
          fail_count++;
        end
        if (m_tdata[20:16] !== want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, m_tdata[20:16]);
          fail_count++;
        end
        if (m_tdata[27:21] !== want.column) begin
          $error("cursor_column: expected %0d, got %0d", want.column, m_tdata[27:21]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either stream
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset contents and cursor, including reads past the screen
  task automatic test_reset_state();
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd0);
    send_command(tcw_pkg::OP_READ, 8'hFF, 11'd1999);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd2000);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'h7FF);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'h2AA);
  endtask

  task automatic test_special_chars();
    send_command(tcw_pkg::OP_PUT, 8'h00, 11'h555);
    send_command(tcw_pkg::OP_PUT, 8'hFF, 11'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::TAB_CHAR, 11'd0);       // short tab, col 2 -> 4
    send_command(tcw_pkg::OP_PUT, tcw_pkg::TAB_CHAR, 11'd0);       // full tab stop of spaces
    send_command(tcw_pkg::OP_PUT, 8'h41, 11'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CHAR, 11'd0);   // pad rest of row
    send_command(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CHAR, 11'd0);   // at column 0: blank row
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd1);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd3);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd8);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd85);
  endtask

  task automatic test_scroll_clear();
    send_command(tcw_pkg::OP_PUT, 8'h7E, 11'd0);
    send_command(tcw_pkg::OP_SCROLL, 8'h00, 11'd0);       // row above 0: keep column
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd80);
    send_command(tcw_pkg::OP_CLEAR, 8'h00, 11'd0);
    send_command(tcw_pkg::OP_PUT, 8'h55, 11'd0);
    send_command(tcw_pkg::OP_SCROLL, 8'h00, 11'd0);       // row 0: column goes home
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd1920);
  endtask

  // Mostly text with newlines and tabs, reads near the cursor, rare scroll and clear
  task automatic run_text(int count);
    int pick;
    int unsigned pos;
    int unsigned back;
    tcw_pkg::opcode_t op;
    logic [7:0] ch;
    logic [10:0] addr;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 999);
      ch   = 8'($urandom_range(8'h20, 8'h7E));
      addr = 11'($urandom_range(0, 2047));
      op   = tcw_pkg::OP_PUT;
      if (pick < 8) begin
        op = tcw_pkg::OP_CLEAR;
      end else if (pick < 28) begin
        op = tcw_pkg::OP_SCROLL;
      end else if (pick < 150) begin
        op   = tcw_pkg::OP_READ;
        pos  = cursor_y * COLUMNS + cursor_x;
        back = $urandom_range(1, 160);
        if ($urandom_range(0, 9) < 6 && pos >= back) addr = 11'(pos - back);
      end else if (pick < 230) begin
        ch = tcw_pkg::NEWLINE_CHAR;
      end else if (pick < 280) begin
        ch = tcw_pkg::TAB_CHAR;
      end else if (pick < 400) begin
        ch = 8'($urandom_range(0, 255));
      end
      send_command(op, ch, addr);
    end
  endtask

  task automatic test_color_phases();
    write_colors(4'hF, 4'h0);
    run_text(180);
    write_colors(4'h0, 4'hF);
    run_text(180);
    write_colors(4'hF, 4'hF);
    run_text(180);
    write_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    run_text(180);
  endtask

  task automatic test_back_to_back();
    write_colors(4'h0, 4'h7);
    steady = 1'b1;
    run_text(80);
    wait_idle();
    steady = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering, then the sender drains
  task automatic test_output_holdoff();
    hold_request = 300;
    for (int k = 0; k < 40; k++) begin
      if (k % 3 == 0) begin
        send_command(tcw_pkg::OP_READ, 8'h00, 11'($urandom_range(0, 2047)));
      end else begin
        send_command(tcw_pkg::OP_PUT, 8'($urandom_range(0, 255)), 11'd0);
      end
    end
    wait_idle();
  endtask

  initial begin
    bg_now = tcw_pkg::BG_RESET;
    fg_now = tcw_pkg::FG_RESET;
    blank_screen();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_special_chars();
    test_scroll_clear();
    test_color_phases();
    test_output_holdoff();
    test_back_to_back();

    // Drain, then look for stray results
    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
